// ===== sv/ppc_pkg.sv =====
// Shared constants, register and opcode codes, and channel-store types for the position controller.
package ppc_pkg;

	localparam int CHANNELS   = 8;
	localparam int RESOLUTION = 100;

	localparam int OP_W      = 2;
	localparam int CH_W      = 3;
	localparam int SMP_W     = 10;
	localparam int FRAC_W    = 8;
	localparam int LVL_W     = SMP_W + FRAC_W;
	localparam int RES_W     = 8;
	localparam int NUM_W     = LVL_W + RES_W;
	localparam int DIV_CNT_W = $clog2(NUM_W);
	localparam int POS_W     = 10;
	localparam int POS_MAX   = 2 ** (POS_W - 1) - 1;
	localparam int POS_MIN   = -(2 ** (POS_W - 1));

	localparam int DUTY_W   = 8;
	localparam int DUTY_MAX = 255;
	localparam int DUTY_MIN = 50;

	localparam int WGT_W     = 16;
	localparam int GAIN_W    = 8;
	localparam int SCALE_W   = 9;
	localparam int DB_W      = 6;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;

	localparam int MA_W      = LVL_W + 2;
	localparam int MD_W      = 2;
	localparam int MB_W      = 16;
	localparam int ACC_W     = MA_W + MD_W + MB_W;
	localparam int MUL_STEPS = MB_W / MD_W;
	localparam int MUL_CNT_W = $clog2(MUL_STEPS);

	localparam logic [OP_W-1:0] OP_SENSE   = 2'd0;
	localparam logic [OP_W-1:0] OP_DRIVE   = 2'd1;
	localparam logic [OP_W-1:0] OP_EXHAUST = 2'd2;
	localparam logic [OP_W-1:0] OP_RELOAD  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_FILTER_WEIGHT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PUSH_GAIN       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PULL_SCALE      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_BOUND_INIT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_BOUND_INIT = 3'd5;

	localparam logic [WGT_W-1:0]   WGT_RST     = 16'd32768;
	localparam logic [GAIN_W-1:0]  GAIN_RST    = 8'd128;
	localparam logic [SCALE_W-1:0] SCALE_RST   = 9'd128;
	localparam logic [DB_W-1:0]    DB_RST      = 6'd2;
	localparam logic [SMP_W-1:0]   LO_INIT_RST = 10'd0;
	localparam logic [SMP_W-1:0]   HI_INIT_RST = 10'd1023;

	typedef struct packed {
		logic             lvl_we;
		logic             dir_we;
		logic             reload;
		logic [CH_W-1:0]  ch;
		logic [LVL_W-1:0] lvl;
		logic [LVL_W-1:0] lo;
		logic [LVL_W-1:0] hi;
		logic             dir;
	} ppc_wr_t;

	typedef struct packed {
		logic [LVL_W-1:0] lvl;
		logic [LVL_W-1:0] lo;
		logic [LVL_W-1:0] hi;
		logic             dir;
	} ppc_rd_t;

endpackage

// ===== sv/ppc_smul.sv =====
// Radix-4 serial multiplier: signed multiplicand times unsigned multiplier, two bits a cycle.
module ppc_smul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ppc_pkg::MA_W-1:0]      a,
	input  logic [ppc_pkg::MB_W-1:0]      b,
	output logic                          done,
	output logic [ppc_pkg::ACC_W-1:0]     prod
);

	logic [ppc_pkg::MA_W-1:0]                 a_q;
	logic [ppc_pkg::MA_W+ppc_pkg::MD_W-1:0]   a3_q;
	logic [ppc_pkg::MB_W-1:0]                 b_q;
	logic [ppc_pkg::ACC_W-1:0]                acc_q;
	logic [ppc_pkg::MUL_CNT_W-1:0]            cnt_q;
	logic                                     busy_q;
	logic                                     done_q;

	logic [ppc_pkg::MA_W+ppc_pkg::MD_W-1:0]   addend;
	logic [ppc_pkg::MA_W+ppc_pkg::MD_W-1:0]   a3;
	logic [ppc_pkg::ACC_W-1:0]                sum;
	logic [ppc_pkg::ACC_W-1:0]                acc_nxt;

	assign a3 = {{ppc_pkg::MD_W{a[ppc_pkg::MA_W-1]}}, a}
		+ {a[ppc_pkg::MA_W-1], a, 1'b0};

	always_comb begin
		case (b_q[ppc_pkg::MD_W-1:0])
			2'd0: addend = '0;
			2'd1: addend = {{ppc_pkg::MD_W{a_q[ppc_pkg::MA_W-1]}}, a_q};
			2'd2: addend = {a_q[ppc_pkg::MA_W-1], a_q, 1'b0};
			default: addend = a3_q;
		endcase
		sum     = acc_q + {addend, {ppc_pkg::MB_W{1'b0}}};
		acc_nxt = {{ppc_pkg::MD_W{sum[ppc_pkg::ACC_W-1]}}, sum[ppc_pkg::ACC_W-1:ppc_pkg::MD_W]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ppc_pkg::MUL_CNT_W'(ppc_pkg::MUL_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			a3_q  <= a3;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_nxt;
			b_q   <= b_q >> ppc_pkg::MD_W;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("multiplier restarted while busy");

endmodule

// ===== sv/ppc_sdiv.sv =====
// Restoring serial divider: one quotient bit a cycle, unsigned operands.
module ppc_sdiv (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ppc_pkg::NUM_W-1:0]     num,
	input  logic [ppc_pkg::LVL_W-1:0]     den,
	output logic                          done,
	output logic [ppc_pkg::NUM_W-1:0]     quo
);

	logic [ppc_pkg::LVL_W-1:0]     den_q;
	logic [ppc_pkg::LVL_W-1:0]     rem_q;
	logic [ppc_pkg::NUM_W-1:0]     quo_q;
	logic [ppc_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;

	logic [ppc_pkg::LVL_W:0]       trial;
	logic [ppc_pkg::LVL_W+1:0]     diff;
	logic                          ge;

	always_comb begin
		trial = {rem_q, quo_q[ppc_pkg::NUM_W-1]};
		diff  = {1'b0, trial} - {2'b00, den_q};
		ge    = !diff[ppc_pkg::LVL_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ppc_pkg::DIV_CNT_W'(ppc_pkg::NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= '0;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= ge ? diff[ppc_pkg::LVL_W-1:0] : trial[ppc_pkg::LVL_W-1:0];
			quo_q <= {quo_q[ppc_pkg::NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

	a_start_ok: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> (!busy_q && den != '0))
		else $error("divider started while busy or with zero divisor");

endmodule

// ===== sv/ppc_chan_mem.sv =====
// Per-channel state: filtered level, tracked bounds and last drive direction.
module ppc_chan_mem (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ppc_pkg::ppc_wr_t              wr,
	input  logic [ppc_pkg::SMP_W-1:0]     lo_init,
	input  logic [ppc_pkg::SMP_W-1:0]     hi_init,
	input  logic [ppc_pkg::CH_W-1:0]      rd_ch,
	output ppc_pkg::ppc_rd_t              rd
);

	logic [ppc_pkg::LVL_W-1:0] lvl_q [ppc_pkg::CHANNELS];
	logic [ppc_pkg::LVL_W-1:0] lo_q  [ppc_pkg::CHANNELS];
	logic [ppc_pkg::LVL_W-1:0] hi_q  [ppc_pkg::CHANNELS];
	logic                      dir_q [ppc_pkg::CHANNELS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < ppc_pkg::CHANNELS; c++) begin
				lvl_q[c] <= '0;
				lo_q[c]  <= {ppc_pkg::LO_INIT_RST, {ppc_pkg::FRAC_W{1'b0}}};
				hi_q[c]  <= {ppc_pkg::HI_INIT_RST, {ppc_pkg::FRAC_W{1'b0}}};
				dir_q[c] <= 1'b0;
			end
		end else begin
			if (wr.reload) begin
				for (int c = 0; c < ppc_pkg::CHANNELS; c++) begin
					lo_q[c] <= {lo_init, {ppc_pkg::FRAC_W{1'b0}}};
					hi_q[c] <= {hi_init, {ppc_pkg::FRAC_W{1'b0}}};
				end
			end
			if (wr.lvl_we) begin
				lvl_q[wr.ch] <= wr.lvl;
				lo_q[wr.ch]  <= wr.lo;
				hi_q[wr.ch]  <= wr.hi;
			end
			if (wr.dir_we) begin
				dir_q[wr.ch] <= wr.dir;
			end
		end
	end

	always_comb begin
		rd.lvl = lvl_q[rd_ch];
		rd.lo  = lo_q[rd_ch];
		rd.hi  = hi_q[rd_ch];
		rd.dir = dir_q[rd_ch];
	end

endmodule

// ===== sv/pneumatic_position_p_controller_unit.sv =====
// Top level of the pneumatic position controller: sequencer, config registers and result register.
//
// Usage: one input word per request on in_valid/in_stall carries op, channel, sample
// and target; exactly one result word leaves on out_valid/out_stall for each.
// Op 0 filters and maps the sample to a position, op 1 also works out valve and
// pump duty, op 2 closes everything, op 3 reloads every channel's bounds.
// The user must write configuration through cfg_we/cfg_index/cfg_data only while the block is
// idle; the block itself does not enforce this. Ops 2 and 3 go straight to the result.
// With op 1 a pull takes longer than a push; the divider is skipped where the bounds are
// equal, and the duty multiply where the error is inside the deadband. The work is done by
// the radix-4 serial multiplier (used once for the filter and once or twice for the duty)
// and the restoring divider of the position mapping, one quotient bit per step.
// One word is worked on at a time; the next is taken in the cycle after the result has
// gone into the output register, even while that register is held by out_stall.
// A stalled result holds until taken. Reset empties the output register, returns the
// sequencer to idle, loads the registers with their defaults and resets channel state.
module pneumatic_position_p_controller_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ppc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ppc_pkg::CFG_W-1:0]         cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [ppc_pkg::OP_W-1:0]          op,
	input  logic [ppc_pkg::CH_W-1:0]          channel,
	input  logic [ppc_pkg::SMP_W-1:0]         sample,
	input  logic signed [ppc_pkg::POS_W-1:0]  target,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [ppc_pkg::CH_W-1:0]          channel_out,
	output logic signed [ppc_pkg::POS_W-1:0]  position,
	output logic                              drive_valid,
	output logic                              supply_valve,
	output logic                              vacuum_valve,
	output logic [ppc_pkg::DUTY_W-1:0]        supply_pwm,
	output logic [ppc_pkg::DUTY_W-1:0]        vacuum_pwm
);

	localparam int STATE_W = 4;
	localparam logic [STATE_W-1:0] S_IDLE = 4'd0;
	localparam logic [STATE_W-1:0] S_FILT = 4'd1;
	localparam logic [STATE_W-1:0] S_MAP1 = 4'd2;
	localparam logic [STATE_W-1:0] S_MAP2 = 4'd3;
	localparam logic [STATE_W-1:0] S_DIV  = 4'd4;
	localparam logic [STATE_W-1:0] S_DRV  = 4'd5;
	localparam logic [STATE_W-1:0] S_MUL1 = 4'd6;
	localparam logic [STATE_W-1:0] S_MUL2 = 4'd7;
	localparam logic [STATE_W-1:0] S_DONE = 4'd8;

	localparam int PUSH_W  = ppc_pkg::POS_W + ppc_pkg::GAIN_W;
	localparam int PULL_W  = PUSH_W + ppc_pkg::SCALE_W;
	localparam int PUSH_SH = 4;
	localparam int PULL_SH = 12;
	localparam int P_W     = 16;

	function automatic logic [ppc_pkg::DUTY_W-1:0] duty_of(input logic [P_W-1:0] p);
		logic [ppc_pkg::DUTY_W-1:0] d;
		if (p > P_W'(ppc_pkg::DUTY_MAX)) begin
			d = ppc_pkg::DUTY_W'(ppc_pkg::DUTY_MAX);
		end else if (p < P_W'(ppc_pkg::DUTY_MIN)) begin
			d = '0;
		end else begin
			d = p[ppc_pkg::DUTY_W-1:0];
		end
		return d;
	endfunction

	logic [STATE_W-1:0]              state_q;

	logic [ppc_pkg::WGT_W-1:0]       wgt_q;
	logic [ppc_pkg::GAIN_W-1:0]      gain_q;
	logic [ppc_pkg::SCALE_W-1:0]     scale_q;
	logic [ppc_pkg::DB_W-1:0]        db_q;
	logic [ppc_pkg::SMP_W-1:0]       lo_init_q;
	logic [ppc_pkg::SMP_W-1:0]       hi_init_q;

	logic [ppc_pkg::OP_W-1:0]        op_q;
	logic [ppc_pkg::CH_W-1:0]        ch_q;
	logic [ppc_pkg::SMP_W-1:0]       smp_q;
	logic [ppc_pkg::POS_W-1:0]       tgt_q;
	logic [ppc_pkg::LVL_W-1:0]       lvl_q;
	logic [ppc_pkg::LVL_W:0]         num_q;
	logic [ppc_pkg::LVL_W:0]         den_q;
	logic                            neg_q;
	logic                            dir_q;

	logic [ppc_pkg::POS_W-1:0]       pos_q;
	logic                            dv_q;
	logic                            sv_q;
	logic                            vv_q;
	logic [ppc_pkg::DUTY_W-1:0]      spwm_q;
	logic [ppc_pkg::DUTY_W-1:0]      vpwm_q;

	logic                            out_valid_q;
	logic [ppc_pkg::CH_W-1:0]        channel_out_q;
	logic [ppc_pkg::POS_W-1:0]       position_q;
	logic                            drive_valid_q;
	logic                            supply_valve_q;
	logic                            vacuum_valve_q;
	logic [ppc_pkg::DUTY_W-1:0]      supply_pwm_q;
	logic [ppc_pkg::DUTY_W-1:0]      vacuum_pwm_q;

	logic                            in_fire;
	logic                            out_free;
	logic                            ch_ok;
	logic                            sense_go;
	logic [ppc_pkg::CH_W-1:0]        rd_ch;
	ppc_pkg::ppc_rd_t                rd;
	ppc_pkg::ppc_wr_t                wr;
	logic [ppc_pkg::LVL_W-1:0]       s8_in;
	logic [ppc_pkg::LVL_W-1:0]       s8_q;
	logic [ppc_pkg::LVL_W:0]         filt_d;

	logic                            mul_start;
	logic [ppc_pkg::MA_W-1:0]        mul_a;
	logic [ppc_pkg::MB_W-1:0]        mul_b;
	logic                            mul_done;
	logic [ppc_pkg::ACC_W-1:0]       mul_prod;

	logic                            div_start;
	logic [ppc_pkg::NUM_W-1:0]       div_num;
	logic [ppc_pkg::LVL_W-1:0]       div_den;
	logic                            div_done;
	logic [ppc_pkg::NUM_W-1:0]       div_quo;

	logic [ppc_pkg::LVL_W:0]         num_neg;
	logic [ppc_pkg::LVL_W:0]         den_neg;
	logic [ppc_pkg::LVL_W-1:0]       num_mag;
	logic [ppc_pkg::POS_W:0]         quo_neg;
	logic [ppc_pkg::POS_W-1:0]       pos_p;
	logic [ppc_pkg::POS_W-1:0]       pos_n;

	logic [ppc_pkg::POS_W:0]         err;
	logic [ppc_pkg::POS_W:0]         err_neg;
	logic [ppc_pkg::POS_W-1:0]       mag;
	logic                            mag_ok;
	logic                            dir_new;
	logic [P_W-1:0]                  p_push;
	logic [P_W-1:0]                  p_pull;

	assign in_stall = (state_q != S_IDLE);
	assign in_fire  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		ch_ok    = (int'(channel) < ppc_pkg::CHANNELS);
		sense_go = (op != ppc_pkg::OP_RELOAD) && (op != ppc_pkg::OP_EXHAUST) && ch_ok;
		rd_ch    = (state_q == S_IDLE) ? channel : ch_q;
		s8_in    = {sample, {ppc_pkg::FRAC_W{1'b0}}};
		s8_q     = {smp_q, {ppc_pkg::FRAC_W{1'b0}}};
		filt_d   = {1'b0, rd.lvl} - {1'b0, s8_in};

		num_neg  = ~num_q + 1'b1;
		den_neg  = ~den_q + 1'b1;
		num_mag  = num_q[ppc_pkg::LVL_W] ? num_neg[ppc_pkg::LVL_W-1:0]
			: num_q[ppc_pkg::LVL_W-1:0];
		div_den  = den_q[ppc_pkg::LVL_W] ? den_neg[ppc_pkg::LVL_W-1:0]
			: den_q[ppc_pkg::LVL_W-1:0];
		div_num  = {{ppc_pkg::RES_W{1'b0}}, num_mag} * ppc_pkg::NUM_W'(ppc_pkg::RESOLUTION);
		div_start = (state_q == S_MAP2) && (den_q != '0);

		quo_neg  = ~div_quo[ppc_pkg::POS_W:0] + 1'b1;
		pos_p    = (div_quo > ppc_pkg::NUM_W'(ppc_pkg::POS_MAX))
			? ppc_pkg::POS_W'(ppc_pkg::POS_MAX) : div_quo[ppc_pkg::POS_W-1:0];
		pos_n    = (div_quo > ppc_pkg::NUM_W'(ppc_pkg::POS_MAX + 1))
			? ppc_pkg::POS_W'(ppc_pkg::POS_MIN) : quo_neg[ppc_pkg::POS_W-1:0];

		err      = {tgt_q[ppc_pkg::POS_W-1], tgt_q} - {pos_q[ppc_pkg::POS_W-1], pos_q};
		err_neg  = ~err + 1'b1;
		mag      = err[ppc_pkg::POS_W] ? err_neg[ppc_pkg::POS_W-1:0] : err[ppc_pkg::POS_W-1:0];
		mag_ok   = (mag >= {{(ppc_pkg::POS_W - ppc_pkg::DB_W){1'b0}}, db_q});
		dir_new  = (err == '0) ? rd.dir : !err[ppc_pkg::POS_W];

		p_push   = P_W'(mul_prod[PUSH_W-1:PUSH_SH]);
		p_pull   = P_W'(mul_prod[PULL_W-1:PULL_SH]);
	end

	always_comb begin
		wr        = '0;
		wr.ch     = ch_q;
		wr.lvl    = lvl_q;
		wr.lo     = (lvl_q < rd.lo) ? lvl_q : rd.lo;
		wr.hi     = (lvl_q > rd.hi) ? lvl_q : rd.hi;
		wr.dir    = dir_new;
		mul_start = 1'b0;
		mul_a     = {filt_d[ppc_pkg::LVL_W], filt_d};
		mul_b     = wgt_q;
		unique case (state_q)
			S_IDLE: begin
				wr.reload = in_fire && (op == ppc_pkg::OP_RELOAD);
				mul_start = in_fire && sense_go;
			end
			S_MAP1: begin
				wr.lvl_we = 1'b1;
			end
			S_DRV: begin
				wr.dir_we = mag_ok;
				mul_start = mag_ok;
				mul_a     = {{(ppc_pkg::MA_W - ppc_pkg::POS_W){1'b0}}, mag};
				mul_b     = {{(ppc_pkg::MB_W - ppc_pkg::GAIN_W){1'b0}}, gain_q};
			end
			S_MUL1: begin
				mul_start = mul_done && !dir_q;
				mul_a     = {{(ppc_pkg::MA_W - PUSH_W){1'b0}}, mul_prod[PUSH_W-1:0]};
				mul_b     = {{(ppc_pkg::MB_W - ppc_pkg::SCALE_W){1'b0}}, scale_q};
			end
			default: begin
			end
		endcase
	end

	ppc_chan_mem u_chan_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.lo_init (lo_init_q),
		.hi_init (hi_init_q),
		.rd_ch   (rd_ch),
		.rd      (rd)
	);

	ppc_smul u_smul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	ppc_sdiv u_sdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wgt_q     <= ppc_pkg::WGT_RST;
			gain_q    <= ppc_pkg::GAIN_RST;
			scale_q   <= ppc_pkg::SCALE_RST;
			db_q      <= ppc_pkg::DB_RST;
			lo_init_q <= ppc_pkg::LO_INIT_RST;
			hi_init_q <= ppc_pkg::HI_INIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ppc_pkg::REG_FILTER_WEIGHT:   wgt_q     <= cfg_data[ppc_pkg::WGT_W-1:0];
				ppc_pkg::REG_PUSH_GAIN:       gain_q    <= cfg_data[ppc_pkg::GAIN_W-1:0];
				ppc_pkg::REG_PULL_SCALE:      scale_q   <= cfg_data[ppc_pkg::SCALE_W-1:0];
				ppc_pkg::REG_DEADBAND:        db_q      <= cfg_data[ppc_pkg::DB_W-1:0];
				ppc_pkg::REG_LOW_BOUND_INIT:  lo_init_q <= cfg_data[ppc_pkg::SMP_W-1:0];
				ppc_pkg::REG_HIGH_BOUND_INIT: hi_init_q <= cfg_data[ppc_pkg::SMP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= sense_go ? S_FILT : S_DONE;
					end
				end
				S_FILT: begin
					if (mul_done) begin
						state_q <= S_MAP1;
					end
				end
				S_MAP1: state_q <= S_MAP2;
				S_MAP2: begin
					if (den_q != '0) begin
						state_q <= S_DIV;
					end else begin
						state_q <= (op_q == ppc_pkg::OP_DRIVE) ? S_DRV : S_DONE;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= (op_q == ppc_pkg::OP_DRIVE) ? S_DRV : S_DONE;
					end
				end
				S_DRV: state_q <= mag_ok ? S_MUL1 : S_DONE;
				S_MUL1: begin
					if (mul_done) begin
						state_q <= dir_q ? S_DONE : S_MUL2;
					end
				end
				S_MUL2: begin
					if (mul_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					op_q   <= op;
					ch_q   <= channel;
					smp_q  <= sample;
					tgt_q  <= target;
					pos_q  <= '0;
					dv_q   <= (op == ppc_pkg::OP_EXHAUST) && ch_ok;
					sv_q   <= 1'b0;
					vv_q   <= 1'b0;
					spwm_q <= '0;
					vpwm_q <= '0;
				end
			end
			S_FILT: begin
				if (mul_done) begin
					lvl_q <= s8_q + mul_prod[ppc_pkg::MB_W +: ppc_pkg::LVL_W];
				end
			end
			S_MAP1: begin
				num_q <= {1'b0, rd.hi} - {1'b0, lvl_q};
				den_q <= {1'b0, rd.hi} - {1'b0, rd.lo};
			end
			S_MAP2: begin
				neg_q <= num_q[ppc_pkg::LVL_W] ^ den_q[ppc_pkg::LVL_W];
				if (den_q == '0) begin
					pos_q <= ppc_pkg::POS_W'(ppc_pkg::RESOLUTION);
				end
			end
			S_DIV: begin
				if (div_done) begin
					pos_q <= neg_q ? pos_n : pos_p;
				end
			end
			S_DRV: begin
				dv_q <= 1'b1;
				if (mag_ok) begin
					dir_q <= dir_new;
				end else begin
					sv_q <= 1'b1;
				end
			end
			S_MUL1: begin
				if (mul_done && dir_q) begin
					sv_q   <= 1'b1;
					spwm_q <= duty_of(p_push);
				end
			end
			S_MUL2: begin
				if (mul_done) begin
					vv_q   <= 1'b1;
					vpwm_q <= duty_of(p_pull);
				end
			end
			S_DONE: begin
				if (out_free) begin
					channel_out_q  <= ch_q;
					position_q     <= pos_q;
					drive_valid_q  <= dv_q;
					supply_valve_q <= sv_q;
					vacuum_valve_q <= vv_q;
					supply_pwm_q   <= spwm_q;
					vacuum_pwm_q   <= vpwm_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid    = out_valid_q;
	assign channel_out  = channel_out_q;
	assign position     = position_q;
	assign drive_valid  = drive_valid_q;
	assign supply_valve = supply_valve_q;
	assign vacuum_valve = vacuum_valve_q;
	assign supply_pwm   = supply_pwm_q;
	assign vacuum_pwm   = vacuum_pwm_q;

	a_valves_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(supply_valve && vacuum_valve))
		else $error("both valves open in one word");

	a_idle_drive: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !drive_valid) |->
			(!supply_valve && !vacuum_valve && supply_pwm == '0 && vacuum_pwm == '0))
		else $error("drive fields set without drive_valid");

	a_pwm_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |->
			((supply_pwm == '0 || (supply_valve && supply_pwm >= 8'd50)) &&
			 (vacuum_pwm == '0 || (vacuum_valve && vacuum_pwm >= 8'd50))))
		else $error("pump duty outside range or without its valve");

endmodule

// ===== verif/pneumatic_position_p_controller_checker.sv =====
// Checker for the position controller: watches the input and output handshakes, predicts each result word and compares.
`timescale 1ns / 100ps

module pneumatic_position_p_controller_checker
	import ppc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  logic [OP_W-1:0]          op,
	input  logic [CH_W-1:0]          channel,
	input  logic [SMP_W-1:0]         sample,
	input  logic signed [POS_W-1:0]  target,
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  logic [CH_W-1:0]          channel_out,
	input  logic signed [POS_W-1:0]  position,
	input  logic                     drive_valid,
	input  logic                     supply_valve,
	input  logic                     vacuum_valve,
	input  logic [DUTY_W-1:0]        supply_pwm,
	input  logic [DUTY_W-1:0]        vacuum_pwm,
	output int                       mismatches,
	output int                       backlog,
	output int                       results_checked
);

	typedef struct packed {
		logic [CH_W-1:0]         ch;
		logic signed [POS_W-1:0] pos;
		logic                    drv;
		logic                    sup_v;
		logic                    vac_v;
		logic [DUTY_W-1:0]       sup_pwm;
		logic [DUTY_W-1:0]       vac_pwm;
	} control_word_t;

	logic [WGT_W-1:0]   weight_reg;
	logic [GAIN_W-1:0]  gain_reg;
	logic [SCALE_W-1:0] scale_reg;
	logic [DB_W-1:0]    deadband_reg;
	logic [SMP_W-1:0]   lo_init_reg;
	logic [SMP_W-1:0]   hi_init_reg;

	logic [LVL_W-1:0] level_mem [CHANNELS];
	logic [LVL_W-1:0] lo_mem    [CHANNELS];
	logic [LVL_W-1:0] hi_mem    [CHANNELS];
	logic             push_mem  [CHANNELS];

	control_word_t pending_words [$];

	task automatic report_mismatch(input string field, input int want, input int got);
		$display("%0t mismatch on %s: expected %0d, got %0d", $realtime, field, want, got);
		mismatches++;
	endtask

	function automatic control_word_t predict_control(input logic [OP_W-1:0] w_op,
			input logic [CH_W-1:0] w_ch, input logic [SMP_W-1:0] w_smp,
			input logic signed [POS_W-1:0] w_tgt);
		control_word_t r;
		longint acc;
		longint lo;
		longint hi;
		longint lvl;
		longint pos;
		longint mag_prod;
		logic [LVL_W-1:0] new_lvl;
		int err;
		int mag;
		int duty;
		r = '0;
		r.ch = w_ch;
		if (w_op == OP_RELOAD) begin
			for (int c = 0; c < CHANNELS; c++) begin
				lo_mem[c] = {lo_init_reg, 8'h00};
				hi_mem[c] = {hi_init_reg, 8'h00};
			end
			return r;
		end
		if (int'(w_ch) >= CHANNELS)
			return r;
		if (w_op == OP_EXHAUST) begin
			r.drv = 1'b1;
			return r;
		end
		acc = longint'(weight_reg) * longint'(level_mem[w_ch])
			+ longint'(65536 - int'(weight_reg)) * longint'({w_smp, 8'h00});
		new_lvl = acc[16 +: LVL_W];
		lo = longint'(lo_mem[w_ch]);
		hi = longint'(hi_mem[w_ch]);
		lvl = longint'(new_lvl);
		if (hi == lo)
			pos = RESOLUTION;
		else
			pos = (longint'(RESOLUTION) * (hi - lvl)) / (hi - lo);
		if (pos > POS_MAX)
			pos = POS_MAX;
		if (pos < POS_MIN)
			pos = POS_MIN;
		level_mem[w_ch] = new_lvl;
		if (new_lvl > hi_mem[w_ch])
			hi_mem[w_ch] = new_lvl;
		if (new_lvl < lo_mem[w_ch])
			lo_mem[w_ch] = new_lvl;
		r.pos = pos[POS_W-1:0];
		if (w_op == OP_DRIVE) begin
			err = int'(w_tgt) - int'(pos);
			mag = (err < 0) ? -err : err;
			r.drv = 1'b1;
			if (mag >= int'(deadband_reg)) begin
				if (err > 0)
					push_mem[w_ch] = 1'b1;
				else if (err < 0)
					push_mem[w_ch] = 1'b0;
				if (push_mem[w_ch])
					mag_prod = (longint'(mag) * longint'(gain_reg)) >> 4;
				else
					mag_prod = (longint'(mag) * longint'(gain_reg) * longint'(scale_reg)) >> 12;
				if (mag_prod > DUTY_MAX)
					duty = DUTY_MAX;
				else if (mag_prod < DUTY_MIN)
					duty = 0;
				else
					duty = int'(mag_prod);
				if (push_mem[w_ch]) begin
					r.sup_v = 1'b1;
					r.sup_pwm = duty[DUTY_W-1:0];
				end else begin
					r.vac_v = 1'b1;
					r.vac_pwm = duty[DUTY_W-1:0];
				end
			end else begin
				r.sup_v = 1'b1;
			end
		end
		return r;
	endfunction

	task automatic compare_control(input control_word_t want);
		if (channel_out !== want.ch)
			report_mismatch("channel_out", int'(want.ch), int'(channel_out));
		if (position !== want.pos)
			report_mismatch("position", int'(want.pos), int'(position));
		if (drive_valid !== want.drv)
			report_mismatch("drive_valid", int'(want.drv), int'(drive_valid));
		if (supply_valve !== want.sup_v)
			report_mismatch("supply_valve", int'(want.sup_v), int'(supply_valve));
		if (vacuum_valve !== want.vac_v)
			report_mismatch("vacuum_valve", int'(want.vac_v), int'(vacuum_valve));
		if (supply_pwm !== want.sup_pwm)
			report_mismatch("supply_pwm", int'(want.sup_pwm), int'(supply_pwm));
		if (vacuum_pwm !== want.vac_pwm)
			report_mismatch("vacuum_pwm", int'(want.vac_pwm), int'(vacuum_pwm));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_reg = WGT_RST;
			gain_reg = GAIN_RST;
			scale_reg = SCALE_RST;
			deadband_reg = DB_RST;
			lo_init_reg = LO_INIT_RST;
			hi_init_reg = HI_INIT_RST;
			for (int c = 0; c < CHANNELS; c++) begin
				level_mem[c] = '0;
				push_mem[c] = 1'b0;
				lo_mem[c] = {LO_INIT_RST, 8'h00};
				hi_mem[c] = {HI_INIT_RST, 8'h00};
			end
			pending_words.delete();
			backlog = 0;
			mismatches = 0;
			results_checked = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FILTER_WEIGHT:   weight_reg = cfg_data[WGT_W-1:0];
					REG_PUSH_GAIN:       gain_reg = cfg_data[GAIN_W-1:0];
					REG_PULL_SCALE:      scale_reg = cfg_data[SCALE_W-1:0];
					REG_DEADBAND:        deadband_reg = cfg_data[DB_W-1:0];
					REG_LOW_BOUND_INIT:  lo_init_reg = cfg_data[SMP_W-1:0];
					REG_HIGH_BOUND_INIT: hi_init_reg = cfg_data[SMP_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				pending_words.push_back(predict_control(op, channel, sample, target));
			if (out_valid && !out_stall) begin
				if (pending_words.size() == 0) begin
					report_mismatch("words pending at result", 1, 0);
				end else begin
					compare_control(pending_words.pop_front());
					results_checked++;
				end
			end
			backlog = pending_words.size();
		end
	end

endmodule

// ===== verif/tb_pneumatic_position_p_controller_unit.sv =====
// Testbench top for the position controller: clock, reset, stimulus, pacing and verdict.
`timescale 1ns / 100ps

module tb_pneumatic_position_p_controller_unit;
	import ppc_pkg::*;

	localparam int HOLD_CYCLES   = 400;
	localparam int STALL_LIMIT   = 4000;
	localparam int PHASE_WORDS   = 62;
	localparam int RANDOM_PHASES = 8;
	localparam int TAIL_CYCLES   = 70;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_W-1:0]        cfg_data;
	logic                    in_valid;
	logic                    in_stall;
	logic [OP_W-1:0]         op;
	logic [CH_W-1:0]         channel;
	logic [SMP_W-1:0]        sample;
	logic signed [POS_W-1:0] target;
	logic                    out_valid;
	logic                    out_stall;
	logic [CH_W-1:0]         channel_out;
	logic signed [POS_W-1:0] position;
	logic                    drive_valid;
	logic                    supply_valve;
	logic                    vacuum_valve;
	logic [DUTY_W-1:0]       supply_pwm;
	logic [DUTY_W-1:0]       vacuum_pwm;

	int mismatches;
	int backlog;
	int results_checked;

	int idle_pct = 0;
	int stall_pct = 0;
	bit hold_req = 1'b0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int words_sent = 0;
	int settings_used = 1;
	logic [SMP_W-1:0] last_sample [CHANNELS];

	pneumatic_position_p_controller_unit DUT (.*);

	pneumatic_position_p_controller_checker u_checker (.*);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", STALL_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	task automatic send_word(input logic [OP_W-1:0] w_op, input logic [CH_W-1:0] w_ch,
			input logic [SMP_W-1:0] w_smp, input logic signed [POS_W-1:0] w_tgt);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		op <= w_op;
		channel <= w_ch;
		sample <= w_smp;
		target <= w_tgt;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (backlog != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_settings(input int wgt, input int gain, input int scale, input int db,
			input int lo_init, input int hi_init);
		logic [CFG_IDX_W-1:0] idx [6];
		int vals [6];
		idx = '{REG_FILTER_WEIGHT, REG_PUSH_GAIN, REG_PULL_SCALE, REG_DEADBAND,
			REG_LOW_BOUND_INIT, REG_HIGH_BOUND_INIT};
		vals = '{wgt, gain, scale, db, lo_init, hi_init};
		in_valid <= 1'b0;
		for (int i = 0; i < 6; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= vals[i][CFG_W-1:0];
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		@(negedge clk);
		settings_used++;
	endtask

	task automatic send_random_word();
		int pick;
		int ch;
		int smp;
		logic signed [POS_W-1:0] tgt;
		logic [OP_W-1:0] w_op;
		pick = $urandom_range(0, 99);
		if (pick < 8)
			w_op = OP_EXHAUST;
		else if (pick < 12)
			w_op = OP_RELOAD;
		else if (pick < 45)
			w_op = OP_SENSE;
		else
			w_op = OP_DRIVE;
		ch = $urandom_range(0, CHANNELS - 1);
		pick = $urandom_range(0, 9);
		if (pick == 0)
			smp = $urandom_range(0, 1) ? 1023 : 0;
		else if (pick < 5)
			smp = $urandom_range(0, 1023);
		else begin
			smp = int'(last_sample[ch]) + $urandom_range(0, 40) - 20;
			if (smp < 0)
				smp = 0;
			if (smp > 1023)
				smp = 1023;
		end
		last_sample[ch] = smp[SMP_W-1:0];
		if ($urandom_range(0, 1))
			tgt = POS_W'($urandom_range(0, 1023));
		else
			tgt = POS_W'($urandom_range(0, 120)) - POS_W'(10);
		send_word(w_op, ch[CH_W-1:0], smp[SMP_W-1:0], tgt);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		op = OP_SENSE;
		channel = '0;
		sample = '0;
		target = '0;
		out_stall = 1'b0;
		for (int c = 0; c < CHANNELS; c++)
			last_sample[c] = SMP_W'(512);
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_word(OP_EXHAUST, 3'd0, 10'd0, 10'sd0);
		send_word(OP_SENSE, 3'd0, 10'd0, 10'sd0);
		send_word(OP_SENSE, 3'd1, 10'd1023, 10'sd0);
		send_word(OP_DRIVE, 3'd0, 10'd1023, 10'sd511);
		send_word(OP_DRIVE, 3'd1, 10'd0, -10'sd512);
		send_word(OP_DRIVE, 3'd2, 10'd512, 10'sd0);
		send_word(OP_DRIVE, 3'd7, 10'd700, 10'sd50);
		send_word(OP_RELOAD, 3'd5, 10'd1023, -10'sd1);
		send_word(OP_DRIVE, 3'd3, 10'd1023, 10'sd100);
		drain_results();

		// equal bounds with no smoothing: zero error in both stored directions
		write_settings(0, 160, 256, 0, 300, 300);
		send_word(OP_RELOAD, 3'd0, 10'd0, 10'sd0);
		send_word(OP_DRIVE, 3'd2, 10'd300, 10'sd100);
		send_word(OP_DRIVE, 3'd2, 10'd300, 10'sd110);
		send_word(OP_DRIVE, 3'd2, 10'd300, 10'sd100);
		send_word(OP_DRIVE, 3'd2, 10'd300, -10'sd512);
		send_word(OP_DRIVE, 3'd4, 10'd300, 10'sd98);
		send_word(OP_DRIVE, 3'd4, 10'd900, 10'sd511);
		send_word(OP_SENSE, 3'd4, 10'd0, 10'sd0);
		drain_results();

		// reversed bounds, zero gain, deadband of 50
		write_settings(65535, 0, 0, 50, 1023, 0);
		send_word(OP_RELOAD, 3'd7, 10'd0, 10'sd0);
		send_word(OP_DRIVE, 3'd5, 10'd512, 10'sd0);
		send_word(OP_DRIVE, 3'd6, 10'd1023, -10'sd512);
		send_word(OP_SENSE, 3'd5, 10'd0, 10'sd0);
		drain_results();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 53; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 53; end
				default: begin idle_pct = 33; stall_pct = 33; end
			endcase
			if (ph == 0)
				write_settings(0, 160, 256, 0, 0, 1023);
			else if (ph == 1)
				write_settings(65535, 0, 0, 50, 1023, 0);
			else
				write_settings($urandom_range(0, 65535), $urandom_range(0, 160),
					$urandom_range(0, 256), $urandom_range(0, 50),
					$urandom_range(0, 1023), $urandom_range(0, 1023));
			send_word(OP_RELOAD, CH_W'($urandom_range(0, 7)), '0, '0);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (ph == 3 && n == 10)
					hold_req = 1'b1;
				send_random_word();
			end
			drain_results();
		end

		repeat (TAIL_CYCLES) @(negedge clk);
		$display("Checked %0d results from %0d input words under %0d register settings.",
			results_checked, words_sent, settings_used);
		$display("Pacing: free flow, sender gaps, receiver stalls, both, one long output hold-off.");
		if (mismatches == 0 && backlog == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
